// ===== rtl/bre_pkg.sv =====
// Shared types and constants for the binary range encoder.
package bre_pkg;

  localparam int PROB_BITS    = 11;
  localparam int RANGE_W      = 32;
  localparam int LOW_W        = RANGE_W + 1;
  localparam int PEND_W       = 32;
  localparam int CNT_W        = 3;

  localparam logic [CNT_W-1:0]   FLUSH_SHIFTS = CNT_W'(5);
  localparam logic [CNT_W-1:0]   NORM_GUARD   = CNT_W'(4);
  localparam logic [RANGE_W-1:0] TOP_LIMIT    = RANGE_W'(1) << 24;
  localparam logic [RANGE_W-1:0] RANGE_INIT   = '1;
  localparam logic [PEND_W-1:0]  PEND_INIT    = PEND_W'(1);
  localparam logic [PEND_W-1:0]  PEND_MAX     = '1;
  localparam logic [7:0]         BYTE_ALL_ONES = 8'hFF;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic                 bit_value;
    logic [PROB_BITS-1:0] probability;
  } item_t;

  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [7:0]  fill_byte;
    logic [31:0] fill_count;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_NORM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;     // capture input item
    logic mul;      // register bound
    logic upd;      // apply coded bit
    logic shift;    // one normalization / low shift
    logic fin;      // release held record as last
    logic restart;  // return coder state to reset values
  } cmd_t;

  typedef struct packed {
    logic emit;        // next low shift emits a record
    logic hold_valid;  // a record waits in the hold register
    logic range_low;   // range below top limit
    logic out_busy;    // output register full and not taken
  } status_t;

endpackage

// ===== rtl/bre_ctrl.sv =====
// Controller state machine sequencing multiply, update, low shifts and release.
module bre_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_kind,
  output logic             item_ready,
  input  bre_pkg::status_t status,
  output bre_pkg::cmd_t    cmd
);
  import bre_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             flush, flush_next;
  logic             active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      flush <= flush_next;
    end
  end

  assign active = (cnt != '0) && (flush || status.range_low);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    flush_next = flush;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          flush_next = (item_kind == KIND_FLUSH);
          if (item_kind == KIND_FLUSH) begin
            cnt_next   = FLUSH_SHIFTS;
            state_next = ST_NORM;
          end else begin
            cnt_next   = NORM_GUARD;
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (active) begin
          // a new emission pushes the held record, which needs a free output slot
          if (!(status.emit && status.hold_valid && status.out_busy)) begin
            cmd.shift = 1'b1;
            cnt_next  = cnt - CNT_W'(1);
          end
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!(status.hold_valid && status.out_busy)) begin
          cmd.fin     = 1'b1;
          cmd.restart = flush;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/bre_datapath.sv =====
// Coder state registers, bound multiplier, low shift and result staging.
module bre_datapath (
  input  logic             clk,
  input  logic             rst,
  input  bre_pkg::item_t   item,
  input  bre_pkg::cmd_t    cmd,
  output bre_pkg::status_t status,
  output logic             result_valid,
  input  logic             result_ready,
  output bre_pkg::result_t result
);
  import bre_pkg::*;

  logic [LOW_W-1:0]     low_acc;
  logic [RANGE_W-1:0]   range_width;
  logic [7:0]           cached_byte;
  logic [PEND_W-1:0]    pending_count;
  logic                 bit_q;
  logic [PROB_BITS-1:0] prob_q;
  logic [RANGE_W-1:0]   bound;
  result_t              hold;
  logic                 hold_valid;

  logic                 carry;
  logic                 emit;
  result_t              rec;
  logic [PEND_W-1:0]    pend_inc;

  assign carry = low_acc[LOW_W-1];
  // low[31:0] < 0xFF000000 exactly when its top byte is not all ones
  assign emit  = (low_acc[RANGE_W-1:RANGE_W-8] != BYTE_ALL_ONES) || carry;

  assign pend_inc = (pending_count == PEND_MAX) ? pending_count
                                                : pending_count + PEND_W'(1);

  always_comb begin
    rec.lead_byte  = cached_byte + {7'b0, carry};
    rec.fill_byte  = carry ? 8'h00 : BYTE_ALL_ONES;
    rec.fill_count = 32'(pending_count - PEND_W'(1));
    rec.last       = 1'b0;
  end

  assign status.emit       = emit;
  assign status.hold_valid = hold_valid;
  assign status.range_low  = (range_width < TOP_LIMIT);
  assign status.out_busy   = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_q  <= item.bit_value;
      prob_q <= (item.probability == '0) ? PROB_BITS'(1) : item.probability;
    end
    if (cmd.mul) begin
      bound <= RANGE_W'(range_width[RANGE_W-1:PROB_BITS]) * RANGE_W'(prob_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      low_acc       <= '0;
      range_width   <= RANGE_INIT;
      cached_byte   <= '0;
      pending_count <= PEND_INIT;
    end else if (cmd.upd) begin
      if (bit_q) begin
        low_acc     <= low_acc + {1'b0, bound};
        range_width <= range_width - bound;
      end else begin
        range_width <= bound;
      end
    end else if (cmd.shift) begin
      range_width <= {range_width[RANGE_W-9:0], 8'h00};
      low_acc     <= {1'b0, low_acc[RANGE_W-9:0], 8'h00};
      if (emit) begin
        cached_byte   <= low_acc[RANGE_W-1:RANGE_W-8];
        pending_count <= PEND_INIT;
      end else begin
        pending_count <= pend_inc;
      end
    end
  end

  // hold keeps the latest record until it is known whether another follows
  always_ff @(posedge clk) begin
    if (cmd.shift && emit) begin
      hold <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.shift && emit) begin
      hold_valid <= 1'b1;
    end else if (cmd.fin) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.shift && emit && hold_valid) || (cmd.fin && hold_valid)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // hold.last is always clear; the release marks the final record
  always_ff @(posedge clk) begin
    if (cmd.shift && emit && hold_valid) begin
      result <= hold;
    end else if (cmd.fin && hold_valid) begin
      result <= '{lead_byte: hold.lead_byte, fill_byte: hold.fill_byte,
                  fill_count: hold.fill_count, last: 1'b1};
    end
  end

endmodule

// ===== rtl/binary_range_encoder_unit.sv =====
// Binary range encoder: one item at a time, results through an output register.
// Encode item: capture, multiply, update, byte shifts while range is low (up to NORM_GUARD), end check, release.
// Flush item: capture, five low shifts, end check, release of the last record.
// The sequencer does one multiply, one update, then one shift per cycle unless the output register holds it.
// A full output register stalls the sequencer only when a record must move into it.
// rst (synchronous) sets low 0, range all ones, cache 0, pending 1, no result.
module binary_range_encoder_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  bre_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output bre_pkg::result_t result
);
  import bre_pkg::*;

  cmd_t    cmd;
  status_t status;

  bre_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  bre_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/bre_checker.sv =====
// Port-level assertions for the range encoder, bound to the top level.
module bre_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input bre_pkg::result_t result
);
  import bre_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while previous one in flight");

  a_fill_value: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.fill_byte == 8'hFF || result.fill_byte == 8'h00))
    else $error("fill byte not 0x00 or 0xFF");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("not quiet after reset");

endmodule

bind binary_range_encoder_unit bre_checker u_bre_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
